@@ rtl/core/qutf8_pkg.sv @@
package qutf8_pkg;

    // Raw-byte fallback base: a failed sequence maps its lead byte to RAW_BASE + byte.
    localparam logic [20:0] RAW_BASE = 21'h0EE000;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned COUNT_W = 3;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 24;

    // Byte counts used for the consumed field.
    localparam logic [COUNT_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [COUNT_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [COUNT_W-1:0] LEN_THREE = 3'd3;
    localparam logic [COUNT_W-1:0] LEN_FOUR  = 3'd4;

    typedef struct packed {
        logic [COUNT_W-1:0] bytes_available;
        logic [7:0]         byte_fourth;
        logic [7:0]         byte_third;
        logic [7:0]         byte_second;
        logic [7:0]         byte_first;
    } window_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bytes_consumed;
        logic [CP_W-1:0]    code_point;
    } result_t;

    localparam int unsigned WINDOW_W = $bits(window_t);
    localparam int unsigned RESULT_W = $bits(result_t);

endpackage

@@ rtl/core/qutf8_stage.sv @@
module qutf8_stage #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;

    // The stage refills in the same cycle that its content leaves.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/qutf8_dec.sv @@
module qutf8_dec (
    input  qutf8_pkg::window_t win,
    output qutf8_pkg::result_t res
);

    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       ge1;
    logic       ge2;
    logic       ge3;
    logic       ge4;
    logic       c1;
    logic       c2;
    logic       c3;
    logic       ok1;
    logic       ok2;
    logic       ok3;
    logic       ok4;

    assign b0 = win.byte_first;
    assign b1 = win.byte_second;
    assign b2 = win.byte_third;
    assign b3 = win.byte_fourth;

    // Counts of five to seven behave as four, so plain compares suffice.
    assign ge1 = (win.bytes_available >= 3'd1);
    assign ge2 = (win.bytes_available >= 3'd2);
    assign ge3 = (win.bytes_available >= 3'd3);
    assign ge4 = (win.bytes_available >= 3'd4);

    assign c1 = (b1[7:6] == 2'b10);
    assign c2 = (b2[7:6] == 2'b10);
    assign c3 = (b3[7:6] == 2'b10);

    assign ok1 = ge1 && (b0 <= 8'h7F);
    assign ok2 = ge2 && (b0 >= 8'hC2) && (b0 <= 8'hDF) && c1;

    assign ok3 = ge3 && c2 &&
                 (((b0 == 8'hE0) && (b1 >= 8'hA0) && (b1 <= 8'hBF)) ||
                  ((b0 >= 8'hE1) && (b0 <= 8'hEC) && c1) ||
                  ((b0 == 8'hED) && (b1 >= 8'h80) && (b1 <= 8'h9F)) ||
                  ((b0 >= 8'hEE) && (b0 <= 8'hEF) && c1));

    assign ok4 = ge4 && c2 && c3 &&
                 (((b0 == 8'hF0) && (b1 >= 8'h90) && (b1 <= 8'hBF)) ||
                  ((b0 >= 8'hF1) && (b0 <= 8'hF3) && c1) ||
                  ((b0 == 8'hF4) && (b1 >= 8'h80) && (b1 <= 8'h8F)));

    always_comb begin
        res.code_point     = qutf8_pkg::RAW_BASE + {13'd0, b0};
        res.bytes_consumed = qutf8_pkg::LEN_ONE;
        if (ok1) begin
            res.code_point = {13'd0, b0};
        end else if (ok2) begin
            res.code_point     = {10'd0, b0[4:0], b1[5:0]};
            res.bytes_consumed = qutf8_pkg::LEN_TWO;
        end else if (ok3) begin
            res.code_point     = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            res.bytes_consumed = qutf8_pkg::LEN_THREE;
        end else if (ok4) begin
            res.code_point     = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            res.bytes_consumed = qutf8_pkg::LEN_FOUR;
        end
    end

endmodule

@@ rtl/core/qutf8_decoder_unit.sv @@
// Strict UTF-8 decoder with raw-byte fallback.
//
// The slave channel carries one window per transaction: up to four bytes and
// the count of valid bytes. The master channel returns one result per window:
// the decoded code point and the number of bytes consumed. Overlong forms,
// surrogates, values above U+10FFFF, bad lead or continuation bytes and
// truncated sequences all fail; a failure returns 0xEE000 plus the lead byte
// with one byte consumed.
//
// From an accepted transaction to m_tvalid, the window is captured in an
// input register, decoded by a short compare network and captured in the
// result register. With m_tready high, throughput is one transaction per cycle,
// set by the two register stages, each of which refills in the cycle it drains.
//
// Reset clears both stage valid flags; no result is pending afterward. When
// m_tready is low the result register holds, the input register fills behind
// it, and then s_tready drops until the master side takes a result.
module qutf8_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] byte_first, [15:8] byte_second, [23:16] byte_third,
    // [31:24] byte_fourth, [34:32] bytes_available, [39:35] zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [20:0] code_point, [23:21] bytes_consumed
    output logic [23:0] m_tdata
);

    qutf8_pkg::window_t win_in;
    qutf8_pkg::window_t win_q;
    qutf8_pkg::result_t res_d;
    qutf8_pkg::result_t res_q;
    logic               win_valid;
    logic               win_ready;

    assign win_in = qutf8_pkg::window_t'(s_tdata[qutf8_pkg::WINDOW_W-1:0]);

    qutf8_stage #(
        .WIDTH(qutf8_pkg::WINDOW_W)
    ) u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (win_in),
        .out_valid(win_valid),
        .out_ready(win_ready),
        .out_data (win_q)
    );

    qutf8_dec u_dec (
        .win(win_q),
        .res(res_d)
    );

    qutf8_stage #(
        .WIDTH(qutf8_pkg::RESULT_W)
    ) u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (win_valid),
        .in_ready (win_ready),
        .in_data  (res_d),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (res_q)
    );

    assign m_tdata = res_q;

    // An accepted window is held in the input stage on the next cycle.
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(s_tvalid && s_tready) |-> win_valid)
        else $error("accepted window not captured");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_q.bytes_consumed >= qutf8_pkg::LEN_ONE) &&
                     (res_q.bytes_consumed <= qutf8_pkg::LEN_FOUR))
        else $error("bytes_consumed out of range");

    // A single-byte result is either ASCII or a raw fallback value.
    a_single_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_q.bytes_consumed == qutf8_pkg::LEN_ONE) |->
            (res_q.code_point <= 21'h00007F) ||
            (res_q.code_point[20:8] == qutf8_pkg::RAW_BASE[20:8]))
        else $error("single-byte result neither ASCII nor raw");

    a_three_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_q.bytes_consumed == qutf8_pkg::LEN_THREE) |->
            (res_q.code_point >= 21'h000800) && (res_q.code_point <= 21'h00FFFF) &&
            ((res_q.code_point < 21'h00D800) || (res_q.code_point > 21'h00DFFF)))
        else $error("three-byte result overlong or surrogate");

    a_four_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_q.bytes_consumed == qutf8_pkg::LEN_FOUR) |->
            (res_q.code_point >= 21'h010000) && (res_q.code_point <= 21'h10FFFF))
        else $error("four-byte result out of range");

endmodule

@@ bench/tb.sv @@
module tb;

    localparam int unsigned CP_W    = qutf8_pkg::CP_W;
    localparam int unsigned COUNT_W = qutf8_pkg::COUNT_W;

    localparam logic [CP_W-1:0]    RAW_BASE  = qutf8_pkg::RAW_BASE;
    localparam logic [COUNT_W-1:0] LEN_ONE   = qutf8_pkg::LEN_ONE;
    localparam logic [COUNT_W-1:0] LEN_TWO   = qutf8_pkg::LEN_TWO;
    localparam logic [COUNT_W-1:0] LEN_THREE = qutf8_pkg::LEN_THREE;
    localparam logic [COUNT_W-1:0] LEN_FOUR  = qutf8_pkg::LEN_FOUR;

    typedef qutf8_pkg::window_t window_t;
    typedef qutf8_pkg::result_t result_t;

    localparam int unsigned RANDOM_PER_PHASE = 534;
    localparam int unsigned LONG_HOLD_CYCLES = 64;
    localparam int unsigned SETTLE_CYCLES    = 8;

    typedef enum int unsigned {
        WELL_FORMED,
        DAMAGED,
        NOISE
    } window_mix_t;

    // One directed window. When known_result is clear, the result comes from decode_window.
    typedef struct packed {
        bit                 known_result;
        logic [COUNT_W-1:0] avail;
        logic [7:0]         b0;
        logic [7:0]         b1;
        logic [7:0]         b2;
        logic [7:0]         b3;
        logic [CP_W-1:0]    cp;
        logic [COUNT_W-1:0] used;
    } directed_row_t;

    localparam int unsigned N_DIRECTED = 25;
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{1'b1, 3'd0, 8'h41, 8'h80, 8'h80, 8'h80, RAW_BASE + 21'h41, LEN_ONE},
        '{1'b1, 3'd1, 8'h00, 8'h00, 8'h00, 8'h00, 21'h000000,        LEN_ONE},
        '{1'b1, 3'd1, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 21'h00007F,        LEN_ONE},
        '{1'b1, 3'd1, 8'h80, 8'h80, 8'h80, 8'h80, RAW_BASE + 21'h80, LEN_ONE},
        '{1'b1, 3'd2, 8'hC0, 8'h80, 8'h00, 8'h00, RAW_BASE + 21'hC0, LEN_ONE},
        '{1'b1, 3'd2, 8'hC1, 8'hBF, 8'h00, 8'h00, RAW_BASE + 21'hC1, LEN_ONE},
        '{1'b1, 3'd2, 8'hC2, 8'h80, 8'h00, 8'h00, 21'h000080,        LEN_TWO},
        '{1'b1, 3'd2, 8'hDF, 8'hBF, 8'hFF, 8'hFF, 21'h0007FF,        LEN_TWO},
        '{1'b1, 3'd1, 8'hC2, 8'h80, 8'h80, 8'h80, RAW_BASE + 21'hC2, LEN_ONE},
        '{1'b1, 3'd2, 8'hC2, 8'hC0, 8'h00, 8'h00, RAW_BASE + 21'hC2, LEN_ONE},
        '{1'b1, 3'd3, 8'hE0, 8'h9F, 8'h80, 8'h00, RAW_BASE + 21'hE0, LEN_ONE},
        '{1'b1, 3'd3, 8'hE0, 8'hA0, 8'h80, 8'h00, 21'h000800,        LEN_THREE},
        '{1'b1, 3'd3, 8'hED, 8'h9F, 8'hBF, 8'h00, 21'h00D7FF,        LEN_THREE},
        '{1'b1, 3'd3, 8'hED, 8'hA0, 8'h80, 8'h00, RAW_BASE + 21'hED, LEN_ONE},
        '{1'b1, 3'd3, 8'hEE, 8'h80, 8'h80, 8'h00, 21'h00E000,        LEN_THREE},
        '{1'b1, 3'd3, 8'hEF, 8'hBF, 8'hBF, 8'hFF, 21'h00FFFF,        LEN_THREE},
        '{1'b1, 3'd2, 8'hE1, 8'h80, 8'h80, 8'h00, RAW_BASE + 21'hE1, LEN_ONE},
        '{1'b1, 3'd4, 8'hF0, 8'h8F, 8'hBF, 8'hBF, RAW_BASE + 21'hF0, LEN_ONE},
        '{1'b1, 3'd4, 8'hF0, 8'h90, 8'h80, 8'h80, 21'h010000,        LEN_FOUR},
        '{1'b1, 3'd4, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 21'h10FFFF,        LEN_FOUR},
        '{1'b1, 3'd4, 8'hF4, 8'h90, 8'h80, 8'h80, RAW_BASE + 21'hF4, LEN_ONE},
        '{1'b1, 3'd4, 8'hF5, 8'h80, 8'h80, 8'h80, RAW_BASE + 21'hF5, LEN_ONE},
        '{1'b1, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, RAW_BASE + 21'hFF, LEN_ONE},
        '{1'b0, 3'd5, 8'hF1, 8'h80, 8'h80, 8'h80, 21'h000000,        LEN_ONE},
        '{1'b1, 3'd3, 8'hF3, 8'hBF, 8'hBF, 8'hBF, RAW_BASE + 21'hF3, LEN_ONE}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    result_t     pending_results[$];
    int unsigned mismatch_count;
    int unsigned results_by_length[5];
    int unsigned fallback_count;
    int unsigned mix_count[3];
    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;

    qutf8_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_cont(logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // Strict decode of the sequence at the start of the window, raw byte on any failure.
    function automatic result_t decode_window(window_t w);
        logic [7:0] b0, b1, b2, b3;
        int unsigned avail;
        bit three_ok, four_ok;
        result_t r;
        b0 = w.byte_first;
        b1 = w.byte_second;
        b2 = w.byte_third;
        b3 = w.byte_fourth;
        avail = (w.bytes_available > 3'd4) ? 4 : w.bytes_available;
        r.code_point = RAW_BASE + {13'd0, b0};
        r.bytes_consumed = LEN_ONE;
        three_ok = avail >= 3 && is_cont(b2) &&
                   ((b0 == 8'hE0 && b1 >= 8'hA0 && b1 <= 8'hBF) ||
                    (b0 >= 8'hE1 && b0 <= 8'hEC && is_cont(b1)) ||
                    (b0 == 8'hED && b1 >= 8'h80 && b1 <= 8'h9F) ||
                    (b0 >= 8'hEE && b0 <= 8'hEF && is_cont(b1)));
        four_ok = avail >= 4 && is_cont(b2) && is_cont(b3) &&
                  ((b0 == 8'hF0 && b1 >= 8'h90 && b1 <= 8'hBF) ||
                   (b0 >= 8'hF1 && b0 <= 8'hF3 && is_cont(b1)) ||
                   (b0 == 8'hF4 && b1 >= 8'h80 && b1 <= 8'h8F));
        if (avail >= 1 && b0 <= 8'h7F) begin
            r.code_point = {13'd0, b0};
        end else if (avail >= 2 && b0 >= 8'hC2 && b0 <= 8'hDF && is_cont(b1)) begin
            r.code_point = {10'd0, b0[4:0], b1[5:0]};
            r.bytes_consumed = LEN_TWO;
        end else if (three_ok) begin
            r.code_point = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            r.bytes_consumed = LEN_THREE;
        end else if (four_ok) begin
            r.code_point = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            r.bytes_consumed = LEN_FOUR;
        end
        return r;
    endfunction

    // Mostly valid encodings of random scalars, some damaged on purpose, some pure noise.
    function automatic window_t random_window(output window_mix_t mix);
        logic [7:0]  seq [4];
        logic [20:0] cp;
        int unsigned len, avail, pick, idx;
        for (int i = 0; i < 4; i++) seq[i] = 8'($urandom_range(255, 0));
        pick = $urandom_range(99, 0);
        len = $urandom_range(4, 1);
        avail = len;
        if ($urandom_range(3, 0) == 0 && len < 7) avail = $urandom_range(7, len + 1);
        case (len)
            1: begin
                cp = 21'($urandom_range('h7F, 0));
                seq[0] = cp[7:0];
            end
            2: begin
                cp = 21'($urandom_range('h7FF, 'h80));
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                cp = 21'($urandom_range('hFFFF, 'h800));
                // Surrogates cannot be encoded; move them up into U+F800..U+FFFF.
                if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                cp = 21'($urandom_range('h10FFFF, 'h10000));
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        if (pick < 60) begin
            mix = WELL_FORMED;
        end else if (pick < 80) begin
            mix = DAMAGED;
            case ($urandom_range(3, 0))
                0: avail = $urandom_range(len - 1, 0);
                1: begin
                    if (len > 1) begin
                        idx = $urandom_range(len - 1, 1);
                        seq[idx][7:6] = 2'($urandom_range(2, 0));
                        if (seq[idx][7:6] == 2'b10) seq[idx][7:6] = 2'b11;
                    end else begin
                        seq[0] = 8'($urandom_range('hBF, 'h80));
                    end
                end
                2: begin
                    case ($urandom_range(2, 0))
                        0: seq[0] = 8'($urandom_range('hBF, 'h80));
                        1: seq[0] = 8'($urandom_range('hC1, 'hC0));
                        default: seq[0] = 8'($urandom_range('hFF, 'hF5));
                    endcase
                end
                default: begin
                    // Leads whose second byte range is narrowed: overlong, surrogate, limit.
                    case ($urandom_range(3, 0))
                        0: seq[0] = 8'hE0;
                        1: seq[0] = 8'hED;
                        2: seq[0] = 8'hF0;
                        default: seq[0] = 8'hF4;
                    endcase
                    seq[1] = 8'($urandom_range('hBF, 'h80));
                    seq[2] = {2'b10, 6'($urandom_range(63, 0))};
                    seq[3] = {2'b10, 6'($urandom_range(63, 0))};
                    avail = 4;
                end
            endcase
        end else begin
            mix = NOISE;
            seq[0] = 8'($urandom_range(255, 0));
            avail = $urandom_range(7, 0);
        end
        return {3'(avail), seq[3], seq[2], seq[1], seq[0]};
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Offer one window and hold it until the transaction completes, then maybe idle.
    task automatic send_window(input window_t w, input result_t want);
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, w};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(want);
        if ($urandom_range(99, 0) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    // Result side: random stalls, plus two long hold-offs that back the block up.
    initial begin
        int unsigned taken;
        int unsigned hold_left;
        int unsigned next_hold_at;
        taken = 0;
        hold_left = 0;
        next_hold_at = 200;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) taken++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (taken >= next_hold_at) begin
                hold_left = LONG_HOLD_CYCLES - 1;
                next_hold_at += 1100;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result cp=%h used=%0d",
                                          got.code_point, got.bytes_consumed));
            end else begin
                want = pending_results.pop_front();
                if (got.code_point !== want.code_point)
                    report_mismatch($sformatf("code_point %h, expected %h",
                                              got.code_point, want.code_point));
                if (got.bytes_consumed !== want.bytes_consumed)
                    report_mismatch($sformatf("bytes_consumed %0d, expected %0d",
                                              got.bytes_consumed, want.bytes_consumed));
                if (want.bytes_consumed <= LEN_FOUR)
                    results_by_length[want.bytes_consumed]++;
                if (want.bytes_consumed == LEN_ONE && want.code_point >= RAW_BASE)
                    fallback_count++;
            end
        end
    end

    initial begin
        #3000000;
        $display("Timeout: %0d results still outstanding.", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        window_t     w;
        result_t     want;
        window_mix_t mix;
        mismatch_count = 0;
        fallback_count = 0;
        foreach (results_by_length[i]) results_by_length[i] = 0;
        foreach (mix_count[i]) mix_count[i] = 0;
        tx_idle_pct = 33;
        rx_stall_pct = 57;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_ROWS[i]) begin
            w = {DIRECTED_ROWS[i].avail, DIRECTED_ROWS[i].b3, DIRECTED_ROWS[i].b2,
                 DIRECTED_ROWS[i].b1, DIRECTED_ROWS[i].b0};
            if (DIRECTED_ROWS[i].known_result)
                want = {DIRECTED_ROWS[i].used, DIRECTED_ROWS[i].cp};
            else
                want = decode_window(w);
            send_window(w, want);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 33; rx_stall_pct = 57; end
                1: begin tx_idle_pct = 57; rx_stall_pct = 33; end
                default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            endcase
            repeat (RANDOM_PER_PHASE) begin
                w = random_window(mix);
                mix_count[mix]++;
                send_window(w, decode_window(w));
            end
        end
        if (s_tvalid) s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d directed windows and %0d random ones",
                 N_DIRECTED, mix_count[WELL_FORMED] + mix_count[DAMAGED] + mix_count[NOISE]);
        $display("(%0d valid, %0d damaged, %0d noise).",
                 mix_count[WELL_FORMED], mix_count[DAMAGED], mix_count[NOISE]);
        $display("Results of 1/2/3/4 bytes: %0d/%0d/%0d/%0d, raw fallbacks %0d, mismatches %0d.",
                 results_by_length[1], results_by_length[2], results_by_length[3],
                 results_by_length[4], fallback_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
